>>> hw/rtl/kmprd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmprd_pkg;

   localparam int KEY_WORD_BITS_DEF = 32;
   localparam int KEY_IN_BITS       = 32;
   localparam int PIXEL_BITS        = 16;

   typedef logic [KEY_IN_BITS-1:0] key_word_type;
   typedef logic [PIXEL_BITS-1:0]  pixel_type;

   // item kind on the request channel
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   // result status codes
   localparam logic STATUS_PIXEL  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_TAKE,
      ST_REJECT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } mask_cmd_type;

   typedef struct packed {
      logic empty;     // no mask bits left, key word needed
      logic count_one; // exactly one mask bit left
      logic top_bit;   // bit about to be used
      logic next_bit;  // bit after it
   } mask_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/kmprd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kmprd_req_if;
   import kmprd_pkg::*;

   logic         valid;
   logic         ready;
   logic         func;
   key_word_type key_word;
   pixel_type    data_pixel;

   modport source (output valid, output func, output key_word, output data_pixel,
                   input ready);
   modport sink   (input valid, input func, input key_word, input data_pixel,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kmprd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kmprd_rsp_if;
   import kmprd_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type out_pixel;
   logic      last;
   logic      status;

   modport source (output valid, output out_pixel, output last, output status,
                   input ready);
   modport sink   (input valid, input out_pixel, input last, input status,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kmprd_mask_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Mask shifter: holds the unused key bits and their count, uses one bit per shift.
module kmprd_mask_unit #(
   parameter int KEY_WORD_BITS = kmprd_pkg::KEY_WORD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kmprd_pkg::mask_cmd_type cmd,
   input  wire kmprd_pkg::key_word_type key_word,
   output kmprd_pkg::mask_sts_type      sts
);
   import kmprd_pkg::*;

   localparam int CNT_W = $clog2(KEY_WORD_BITS + 1);

   logic [KEY_WORD_BITS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [KEY_WORD_BITS-1:0] load_value;

   generate
      if (KEY_WORD_BITS > KEY_IN_BITS) begin : g_wide
         assign load_value = {{(KEY_WORD_BITS-KEY_IN_BITS){1'b0}}, key_word};
      end else if (KEY_WORD_BITS == KEY_IN_BITS) begin : g_same
         assign load_value = key_word;
      end else begin : g_narrow
         assign load_value = key_word[KEY_WORD_BITS-1:0];
      end
   endgenerate

   always_comb begin
      mask_in  = mask_ff;
      count_in = count_ff;
      priority if (cmd.load) begin
         mask_in  = load_value;
         count_in = CNT_W'(KEY_WORD_BITS);
      end else if (cmd.shift) begin
         mask_in  = {mask_ff[KEY_WORD_BITS-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         count_ff <= '0;
      end else begin
         mask_ff  <= mask_in;
         count_ff <= count_in;
      end
   end

   assign sts.empty     = (count_ff == '0);
   assign sts.count_one = (count_ff == CNT_W'(1));
   assign sts.top_bit   = mask_ff[KEY_WORD_BITS-1];
   assign sts.next_bit  = mask_ff[KEY_WORD_BITS-2];

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.shift)
      else $error("mask load and shift together");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> !sts.empty)
      else $error("mask shift with no bits left");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.empty)
      else $error("key loaded while bits remain");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(KEY_WORD_BITS))
      else $error("mask bit count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/key_mask_pixel_repeat_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                         Transfer
// req_bus   in   func, key_word, data_pixel      valid & ready
// rsp_bus   out  out_pixel, last, status         valid & ready
//
// Key word: taken in idle; leading repeat bits used in run state; then back to idle.
// Data pixel: taken, emitted in take state, again per following repeat bit, then idle.
// Rejected item: one reject result. Every bit goes through the single-bit mask shifter.
// Results leave through one output register; rsp_ready low holds the next result back.
// Synchronous active-high reset: no key word loaded, no pixel held.
module key_mask_pixel_repeat_decoder #(
   parameter int KEY_WORD_BITS = kmprd_pkg::KEY_WORD_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kmprd_req_if.sink   req_bus,
   kmprd_rsp_if.source rsp_bus
);
   import kmprd_pkg::*;

   state_type    state_ff, state_in;
   mask_cmd_type mask_cmd;
   mask_sts_type mask_sts;

   pixel_type held_pixel_ff, held_pixel_in;
   logic      held_valid_ff, held_valid_in;

   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type pixel_ff, pixel_in;
   logic      last_ff, last_in;
   logic      status_ff, status_in;

   logic req_ready;
   logic accept;
   logic reject;
   logic slot_free;
   logic take_pixel;
   logic emit_pix;
   logic emit_err;

   kmprd_mask_unit #(
      .KEY_WORD_BITS (KEY_WORD_BITS)
   ) u_mask (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mask_cmd),
      .key_word (req_bus.key_word),
      .sts      (mask_sts)
   );

   assign accept    = req_bus.valid && req_ready;
   assign reject    = (req_bus.func == FUNC_KEY) ? !mask_sts.empty : mask_sts.empty;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (reject)                    state_in = ST_REJECT;
               else if (req_bus.func == FUNC_DATA)     state_in = ST_TAKE;
               else                                    state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (mask_sts.empty || !mask_sts.top_bit) state_in = ST_IDLE;
         end
         ST_TAKE: begin
            if (slot_free) state_in = ST_RUN;
         end
         ST_REJECT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      mask_cmd.load  = 1'b0;
      mask_cmd.shift = 1'b0;
      take_pixel     = 1'b0;
      emit_pix       = 1'b0;
      emit_err       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && !reject) begin
               mask_cmd.load = (req_bus.func == FUNC_KEY);
               take_pixel    = (req_bus.func == FUNC_DATA);
            end
         end
         ST_RUN: begin
            // repeat bits before any pixel are used without a result
            if (!mask_sts.empty && mask_sts.top_bit) begin
               if (!held_valid_ff) begin
                  mask_cmd.shift = 1'b1;
               end else if (slot_free) begin
                  mask_cmd.shift = 1'b1;
                  emit_pix       = 1'b1;
               end
            end
         end
         ST_TAKE: begin
            if (slot_free) begin
               mask_cmd.shift = 1'b1;
               emit_pix       = 1'b1;
            end
         end
         ST_REJECT: begin
            emit_err = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      held_pixel_in = take_pixel ? req_bus.data_pixel : held_pixel_ff;
      held_valid_in = held_valid_ff || take_pixel;
   end

   // once a pixel is held every later repeat bit emits, so the run ends
   // after the last bit or before the next take bit
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pixel_in     = pixel_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      priority if (emit_pix) begin
         rsp_valid_in = 1'b1;
         pixel_in     = held_pixel_ff;
         last_in      = mask_sts.count_one || !mask_sts.next_bit;
         status_in    = STATUS_PIXEL;
      end else if (emit_err) begin
         rsp_valid_in = 1'b1;
         pixel_in     = '0;
         last_in      = 1'b1;
         status_in    = STATUS_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_pixel_ff <= held_pixel_in;
      pixel_ff      <= pixel_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
   end

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_pixel = pixel_ff;
   assign rsp_bus.last      = last_ff;
   assign rsp_bus.status    = status_ff;

   a_pix_needs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_PIXEL) |-> held_valid_ff)
      else $error("pixel result without a held pixel");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_REJECT) |-> last_ff && (pixel_ff == '0))
      else $error("malformed reject result");

   a_take_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE) |-> !mask_sts.empty && held_valid_ff)
      else $error("take state without a pending mask bit");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (emit_pix || emit_err) |-> slot_free)
      else $error("result would overwrite an untaken result");

endmodule

`default_nettype wire
